FILE: src/assert_macros.svh
// assertion macros shared by the checker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/tlvmc_pkg.sv
// types and constants of the tlv message checker
package tlvmc_pkg;

   typedef enum logic [1:0] {
      PH_MSG_HDR = 2'd0,
      PH_REC_HDR = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ERR_OK         = 3'd0,
      ERR_SHORT      = 3'd1,
      ERR_BAD_HEADER = 3'd2,
      ERR_OVERRUN    = 3'd3,
      ERR_TOO_LONG   = 3'd4
   } err_type;

   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   localparam logic CSR_IDX_RAW_TYPE = 1'b0;
   localparam logic CSR_IDX_WANTED   = 1'b1;
   localparam int   CSR_ADDR_W       = 3;

   localparam logic [31:0] HDR_BYTES    = 32'd8;
   localparam logic [2:0]  HDR_LAST_IDX = 3'd7;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // what one input byte produced: an optional match and an optional verdict
   typedef struct packed {
      logic        has_match;
      logic [15:0] match_offset;
      logic [31:0] match_size;
      logic        has_verdict;
      err_type     verdict_err;
   } event_type;

endpackage

FILE: src/tlv_message_checker.sv
// tlv message checker: takes one byte per cycle while req_stall is low; a result passes the
// event queue and output register; results leave at one per cycle while rsp_stall is low,
// so a byte that ends a message on a matching record header gives two results.
// the four-entry event queue stalls the input only when results back up behind rsp_stall.
// reset clears parser state, the queue and the registers; no clearing pass is needed.
`include "assert_macros.svh"

module tlv_message_checker #(
   parameter int MAX_MSG_BYTES = 65536
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [7:0]                       req_data_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_result_kind,
   output logic [15:0]                      rsp_value_offset,
   output logic [31:0]                      rsp_record_size,
   output logic                             rsp_message_valid,
   output logic [2:0]                       rsp_error_code,
   output logic                             rsp_last,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [tlvmc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   logic [7:0]           raw_type_ff;
   logic [31:0]          wanted_type_ff;
   logic                 csr_write;
   logic                 csr_idx;
   logic                 accept;
   logic                 q_push;
   logic                 q_pop;
   logic                 q_empty;
   logic                 q_full;
   tlvmc_pkg::event_type push_event;
   tlvmc_pkg::event_type head_event;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_type_ff    <= 8'd0;
         wanted_type_ff <= 32'd0;
      end else if (csr_write) begin
         unique case (csr_idx)
            tlvmc_pkg::CSR_IDX_RAW_TYPE: raw_type_ff    <= csr_pwdata[7:0];
            tlvmc_pkg::CSR_IDX_WANTED:   wanted_type_ff <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         tlvmc_pkg::CSR_IDX_RAW_TYPE: csr_prdata = {24'd0, raw_type_ff};
         tlvmc_pkg::CSR_IDX_WANTED:   csr_prdata = wanted_type_ff;
         default:                     csr_prdata = 32'd0;
      endcase
   end

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;

   tlvmc_front #(
      .MAX_MSG_BYTES (MAX_MSG_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .data_byte     (req_data_byte),
      .last_byte     (req_last_byte),
      .raw_type_code (raw_type_ff),
      .wanted_type   (wanted_type_ff),
      .push          (q_push),
      .push_event    (push_event)
   );

   tlvmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_event (push_event),
      .pop        (q_pop),
      .head_event (head_event),
      .empty      (q_empty),
      .full       (q_full)
   );

   tlvmc_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_event        (head_event),
      .empty             (q_empty),
      .pop               (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_value_offset  (rsp_value_offset),
      .rsp_record_size   (rsp_record_size),
      .rsp_message_valid (rsp_message_valid),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last)
   );

   `ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(q_push && q_full), "event pushed into full queue")
   `ASSERT_IMPLY(a_verdict_is_last, clock, reset, rsp_valid && rsp_result_kind == tlvmc_pkg::KIND_VERDICT, rsp_last, "verdict item without last")
   `ASSERT_IMPLY(a_rsp_from_queue, clock, reset, $rose(rsp_valid), $past(!q_empty), "result appeared with empty queue")

endmodule

FILE: src/tlvmc_front.sv
// byte parser: walks headers and records, classifies each byte into events
module tlvmc_front #(
   parameter int MAX_MSG_BYTES = 65536
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   input  logic [7:0]           raw_type_code,
   input  logic [31:0]          wanted_type,
   output logic                 push,
   output tlvmc_pkg::event_type push_event
);

   localparam int CNT_W = $clog2(MAX_MSG_BYTES + 2);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_MSG_BYTES);

   tlvmc_pkg::phase_type phase_ff, phase_in, phase_adv;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, cnt_adv;
   logic [2:0]           hdr_cnt_ff, hdr_cnt_in, hdr_cnt_adv;
   logic                 too_long_ff, too_long_in, too_long_adv;
   logic                 type_ok_ff, type_ok_in, type_ok_adv;
   logic [31:0]          declared_ff, declared_in, declared_adv;
   logic [31:0]          payload_left_ff, payload_left_in;
   logic [63:0]          shift_ff, shift_in;

   logic        in_header;
   logic        hdr_done;
   logic [31:0] lo_word;
   logic [31:0] hi_word;
   logic [31:0] cnt_ext;
   logic        match;
   tlvmc_pkg::err_type verdict_err;

   assign in_header = (phase_ff != tlvmc_pkg::PH_PAYLOAD);
   assign hdr_done  = in_header && (hdr_cnt_ff == tlvmc_pkg::HDR_LAST_IDX);
   assign shift_in  = in_header ? {data_byte, shift_ff[63:8]} : shift_ff;
   assign lo_word   = shift_in[31:0];
   assign hi_word   = shift_in[63:32];

   // next phase
   always_comb begin
      phase_adv = phase_ff;
      unique case (phase_ff)
         tlvmc_pkg::PH_MSG_HDR: begin
            if (hdr_done) phase_adv = tlvmc_pkg::PH_REC_HDR;
         end
         tlvmc_pkg::PH_REC_HDR: begin
            if (hdr_done && hi_word != 32'd0) phase_adv = tlvmc_pkg::PH_PAYLOAD;
         end
         tlvmc_pkg::PH_PAYLOAD: begin
            if (payload_left_ff == 32'd1) phase_adv = tlvmc_pkg::PH_REC_HDR;
         end
         default: phase_adv = tlvmc_pkg::PH_MSG_HDR;
      endcase
      phase_in = last_byte ? tlvmc_pkg::PH_MSG_HDR : phase_adv;
   end

   // counters, header fields and events
   always_comb begin
      cnt_adv      = (cnt_ff <= MAX_CNT) ? cnt_ff + CNT_W'(1) : cnt_ff;
      too_long_adv = too_long_ff || (cnt_adv > MAX_CNT);
      hdr_cnt_adv  = in_header ? hdr_cnt_ff + 3'd1 : hdr_cnt_ff;
      cnt_ext      = 32'(cnt_adv);

      type_ok_adv  = type_ok_ff;
      declared_adv = declared_ff;
      if (hdr_done && phase_ff == tlvmc_pkg::PH_MSG_HDR) begin
         type_ok_adv  = (lo_word[7:0] == raw_type_code);
         declared_adv = hi_word;
      end

      payload_left_in = payload_left_ff;
      if (phase_ff == tlvmc_pkg::PH_PAYLOAD) begin
         payload_left_in = payload_left_ff - 32'd1;
      end else if (hdr_done && phase_ff == tlvmc_pkg::PH_REC_HDR) begin
         payload_left_in = hi_word;
      end

      match = hdr_done && (phase_ff == tlvmc_pkg::PH_REC_HDR) &&
              (lo_word == wanted_type) && !too_long_adv;

      if (too_long_adv) begin
         verdict_err = tlvmc_pkg::ERR_TOO_LONG;
      end else if (cnt_ext < tlvmc_pkg::HDR_BYTES) begin
         verdict_err = tlvmc_pkg::ERR_SHORT;
      end else if (!type_ok_adv || declared_adv != cnt_ext - tlvmc_pkg::HDR_BYTES) begin
         verdict_err = tlvmc_pkg::ERR_BAD_HEADER;
      end else if (phase_adv == tlvmc_pkg::PH_PAYLOAD || hdr_cnt_adv != 3'd0) begin
         verdict_err = tlvmc_pkg::ERR_OVERRUN;
      end else begin
         verdict_err = tlvmc_pkg::ERR_OK;
      end

      // a final byte starts the next message from scratch
      cnt_in      = last_byte ? '0 : cnt_adv;
      too_long_in = last_byte ? 1'b0 : too_long_adv;
      hdr_cnt_in  = last_byte ? 3'd0 : hdr_cnt_adv;
      type_ok_in  = last_byte ? 1'b0 : type_ok_adv;
      declared_in = last_byte ? 32'd0 : declared_adv;

      push                    = accept && (match || last_byte);
      push_event.has_match    = match;
      push_event.match_offset = cnt_ext[15:0];
      push_event.match_size   = hi_word;
      push_event.has_verdict  = last_byte;
      push_event.verdict_err  = verdict_err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= tlvmc_pkg::PH_MSG_HDR;
         cnt_ff          <= '0;
         hdr_cnt_ff      <= 3'd0;
         too_long_ff     <= 1'b0;
         type_ok_ff      <= 1'b0;
         declared_ff     <= 32'd0;
         payload_left_ff <= 32'd0;
      end else if (accept) begin
         phase_ff        <= phase_in;
         cnt_ff          <= cnt_in;
         hdr_cnt_ff      <= hdr_cnt_in;
         too_long_ff     <= too_long_in;
         type_ok_ff      <= type_ok_in;
         declared_ff     <= declared_in;
         payload_left_ff <= payload_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) shift_ff <= shift_in;
   end

endmodule

FILE: src/tlvmc_queue.sv
// small event queue between the parser and the result stage
module tlvmc_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tlvmc_pkg::event_type push_event,
   input  logic                 pop,
   output tlvmc_pkg::event_type head_event,
   output logic                 empty,
   output logic                 full
);

   tlvmc_pkg::event_type                 mem_ff [tlvmc_pkg::QUEUE_DEPTH];
   logic [tlvmc_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [tlvmc_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [tlvmc_pkg::QPTR_W:0]           count_ff, count_in;

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == (tlvmc_pkg::QPTR_W+1)'(tlvmc_pkg::QUEUE_DEPTH));
   assign head_event = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + tlvmc_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + tlvmc_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + (tlvmc_pkg::QPTR_W+1)'(1);
      if (pop && !push) count_in = count_ff - (tlvmc_pkg::QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_event;
   end

endmodule

FILE: src/tlvmc_back.sv
// result stage: expands each event into match and verdict items
module tlvmc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tlvmc_pkg::event_type head_event,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_result_kind,
   output logic [15:0]          rsp_value_offset,
   output logic [31:0]          rsp_record_size,
   output logic                 rsp_message_valid,
   output logic [2:0]           rsp_error_code,
   output logic                 rsp_last
);

   logic        valid_ff, valid_in;
   logic        match_sent_ff, match_sent_in;
   logic        kind_ff, kind_in;
   logic [15:0] offset_ff, offset_in;
   logic [31:0] size_ff, size_in;
   logic        msg_ok_ff, msg_ok_in;
   logic [2:0]  err_ff, err_in;
   logic        last_ff, last_in;
   logic        load;
   logic        match_pending;

   assign load          = !empty && (!valid_ff || !rsp_stall);
   assign match_pending = head_event.has_match && !match_sent_ff;

   always_comb begin
      valid_in      = load ? 1'b1 : (valid_ff && rsp_stall);
      match_sent_in = match_sent_ff;
      pop           = 1'b0;
      kind_in       = kind_ff;
      offset_in     = offset_ff;
      size_in       = size_ff;
      msg_ok_in     = msg_ok_ff;
      err_in        = err_ff;
      last_in       = last_ff;
      if (load) begin
         if (match_pending) begin
            kind_in   = tlvmc_pkg::KIND_MATCH;
            offset_in = head_event.match_offset;
            size_in   = head_event.match_size;
            msg_ok_in = 1'b0;
            err_in    = tlvmc_pkg::ERR_OK;
            last_in   = !head_event.has_verdict;
            // a verdict still follows from the same entry
            if (head_event.has_verdict) begin
               match_sent_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            kind_in       = tlvmc_pkg::KIND_VERDICT;
            offset_in     = 16'd0;
            size_in       = 32'd0;
            msg_ok_in     = (head_event.verdict_err == tlvmc_pkg::ERR_OK);
            err_in        = head_event.verdict_err;
            last_in       = 1'b1;
            match_sent_in = 1'b0;
            pop           = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         match_sent_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         match_sent_ff <= match_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      offset_ff <= offset_in;
      size_ff   <= size_in;
      msg_ok_ff <= msg_ok_in;
      err_ff    <= err_in;
      last_ff   <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_value_offset  = offset_ff;
   assign rsp_record_size   = size_ff;
   assign rsp_message_valid = msg_ok_ff;
   assign rsp_error_code    = err_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: bench/tb_tlv_message_checker.sv
// self-checking testbench for the tlv message checker: directed and random messages
module tb_tlv_message_checker;

   localparam int MSG_LIMIT     = 65536;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_BYTES   = 220;
   localparam int CYCLE_LIMIT   = 2_000_000;

   typedef struct packed {
      logic        kind;
      logic [15:0] offset;
      logic [31:0] size;
      logic        ok;
      logic [2:0]  code;
      logic        last;
   } outcome_type;

   // follows the record walk byte by byte and holds the outcomes still to come
   class message_walker;
      logic [7:0]           raw_code;
      logic [31:0]          wanted;
      int unsigned          byte_count;
      tlvmc_pkg::phase_type phase;
      logic [63:0]          hdr_shift;
      logic [31:0]          decl_len;
      logic                 hdr_ok;
      logic [31:0]          left;
      logic                 too_long;
      logic [2:0]           hdr_count;
      outcome_type          due_outcomes[$];
      int                   errors;

      function new();
         raw_code = 8'h00;
         wanted = 32'h0;
         errors = 0;
         restart();
      endfunction

      function void restart();
         byte_count = 0;
         phase = tlvmc_pkg::PH_MSG_HDR;
         hdr_shift = 64'h0;
         decl_len = 32'h0;
         hdr_ok = 1'b0;
         left = 32'h0;
         too_long = 1'b0;
         hdr_count = 3'd0;
      endfunction

      function void take_byte(logic [7:0] data, logic fin);
         outcome_type         o;
         tlvmc_pkg::err_type  verdict;
         if (byte_count <= MSG_LIMIT) byte_count++;
         if (byte_count > MSG_LIMIT) too_long = 1'b1;
         if (phase == tlvmc_pkg::PH_PAYLOAD) begin
            left--;
            if (left == 0) phase = tlvmc_pkg::PH_REC_HDR;
         end else begin
            hdr_shift = {data, hdr_shift[63:8]};
            hdr_count++;
            if (hdr_count == 3'd0) begin
               if (phase == tlvmc_pkg::PH_MSG_HDR) begin
                  hdr_ok = (hdr_shift[7:0] == raw_code);
                  decl_len = hdr_shift[63:32];
                  phase = tlvmc_pkg::PH_REC_HDR;
               end else begin
                  if (hdr_shift[31:0] == wanted && !too_long) begin
                     o = '{kind: tlvmc_pkg::KIND_MATCH, offset: byte_count[15:0],
                           size: hdr_shift[63:32], ok: 1'b0, code: tlvmc_pkg::ERR_OK,
                           last: !fin};
                     due_outcomes.push_back(o);
                  end
                  if (hdr_shift[63:32] != 0) begin
                     left = hdr_shift[63:32];
                     phase = tlvmc_pkg::PH_PAYLOAD;
                  end else begin
                     phase = tlvmc_pkg::PH_REC_HDR;
                  end
               end
            end
         end
         if (fin) begin
            if (too_long)
               verdict = tlvmc_pkg::ERR_TOO_LONG;
            else if (byte_count < tlvmc_pkg::HDR_BYTES)
               verdict = tlvmc_pkg::ERR_SHORT;
            else if (!hdr_ok || decl_len != byte_count - tlvmc_pkg::HDR_BYTES)
               verdict = tlvmc_pkg::ERR_BAD_HEADER;
            else if (phase == tlvmc_pkg::PH_PAYLOAD || hdr_count != 3'd0)
               verdict = tlvmc_pkg::ERR_OVERRUN;
            else
               verdict = tlvmc_pkg::ERR_OK;
            o = '{kind: tlvmc_pkg::KIND_VERDICT, offset: 16'h0, size: 32'h0,
                  ok: (verdict == tlvmc_pkg::ERR_OK), code: verdict, last: 1'b1};
            due_outcomes.push_back(o);
            restart();
         end
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            errors++;
         end
      endfunction

      function void check_outcome(outcome_type seen);
         outcome_type want;
         if (due_outcomes.size() == 0) begin
            $error("result_kind: expected no result, got 0x%0h", seen.kind);
            errors++;
            return;
         end
         want = due_outcomes.pop_front();
         compare_field("result_kind", 32'(want.kind), 32'(seen.kind));
         compare_field("value_offset", 32'(want.offset), 32'(seen.offset));
         compare_field("record_size", want.size, seen.size);
         compare_field("message_valid", 32'(want.ok), 32'(seen.ok));
         compare_field("error_code", 32'(want.code), 32'(seen.code));
         compare_field("last", 32'(want.last), 32'(seen.last));
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset;
   logic                             req_valid;
   logic                             req_stall;
   logic [7:0]                       req_data_byte;
   logic                             req_last_byte;
   logic                             rsp_valid;
   logic                             rsp_stall;
   logic                             rsp_result_kind;
   logic [15:0]                      rsp_value_offset;
   logic [31:0]                      rsp_record_size;
   logic                             rsp_message_valid;
   logic [2:0]                       rsp_error_code;
   logic                             rsp_last;
   logic                             csr_psel;
   logic                             csr_penable;
   logic                             csr_pwrite;
   logic [tlvmc_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]                      csr_pwdata;
   logic [31:0]                      csr_prdata;
   logic                             csr_pready;

   message_walker walker;
   logic [7:0]    msg_q[$];
   bit            idle_on = 1'b1;
   bit            hold_req = 1'b0;
   int            sent_bytes = 0;
   int            cycles = 0;

   tlv_message_checker #(.MAX_MSG_BYTES(MSG_LIMIT)) u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_last_byte     (req_last_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_value_offset  (rsp_value_offset),
      .rsp_record_size   (rsp_record_size),
      .rsp_message_valid (rsp_message_valid),
      .rsp_error_code    (rsp_error_code),
      .rsp_last          (rsp_last),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      outcome_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) walker.take_byte(req_data_byte, req_last_byte);
         if (rsp_valid && !rsp_stall) begin
            seen = '{kind: rsp_result_kind, offset: rsp_value_offset, size: rsp_record_size,
                     ok: rsp_message_valid, code: rsp_error_code, last: rsp_last};
            walker.check_outcome(seen);
         end
      end
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99) < 30);
         end
      end
   end

   function automatic void push_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) msg_q.push_back(w[8*i +: 8]);
   endfunction

   function automatic void prepend_header(logic [31:0] htype, logic [31:0] hlen);
      logic [63:0] hdr;
      hdr = {hlen, htype};
      for (int i = 7; i >= 0; i--) msg_q.push_front(hdr[8*i +: 8]);
   endfunction

   // mostly well-formed messages, some cut short, overrunning, with a bad header, or noise
   function automatic void build_random_message();
      int          pick;
      int          cut;
      logic [31:0] rtype;
      logic [31:0] rsize;
      logic [31:0] htype;
      logic [31:0] hlen;
      msg_q.delete();
      pick = $urandom_range(99);
      if (pick >= 92) begin
         repeat ($urandom_range(20, 1)) msg_q.push_back(8'($urandom));
         return;
      end
      repeat ($urandom_range(4)) begin
         case ($urandom_range(3))
            0, 1:    rtype = walker.wanted;
            2:       rtype = walker.wanted ^ (32'h1 << $urandom_range(31));
            default: rtype = $urandom;
         endcase
         rsize = $urandom_range(6);
         push_word(rtype);
         push_word(rsize);
         repeat (rsize) msg_q.push_back(8'($urandom));
      end
      if (pick >= 70 && pick < 78 && msg_q.size() > 0) begin
         cut = $urandom_range(msg_q.size() - 1);
         while (msg_q.size() > cut) void'(msg_q.pop_back());
      end else if (pick >= 78 && pick < 84) begin
         // trailing record whose payload runs past the end
         push_word($urandom_range(1) ? walker.wanted : $urandom);
         push_word($urandom | 32'h100);
         repeat ($urandom_range(3)) msg_q.push_back(8'($urandom));
      end
      htype = {24'($urandom), walker.raw_code};
      hlen = msg_q.size();
      if (pick >= 84 && pick < 88) htype[7:0] = walker.raw_code ^ 8'($urandom_range(255, 1));
      if (pick >= 88 && pick < 92) hlen = hlen ^ (32'h1 << $urandom_range(31));
      prepend_header(htype, hlen);
   endfunction

   task automatic send_range(int from, int upto);
      for (int i = from; i < upto; i++) begin
         while (idle_on && $urandom_range(99) < 30) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data_byte <= msg_q[i];
         req_last_byte <= (i == msg_q.size() - 1);
         do @(posedge clock); while (req_stall);
         sent_bytes++;
      end
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (walker.due_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      logic [31:0] mask;
      mask = (idx == tlvmc_pkg::CSR_IDX_RAW_TYPE) ? 32'h0000_00ff : 32'hffff_ffff;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= tlvmc_pkg::CSR_ADDR_W'(4 * idx);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read back the same register
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if ((csr_prdata & mask) !== (value & mask)) begin
         $error("csr_prdata: expected 0x%0h, got 0x%0h", value & mask, csr_prdata & mask);
         walker.errors++;
      end
      if (idx == tlvmc_pkg::CSR_IDX_RAW_TYPE) walker.raw_code = value[7:0];
      else walker.wanted = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          phase_start;
      logic [7:0]  raw_pick;
      logic [31:0] wanted_pick;
      walker = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data_byte = 8'h00;
      req_last_byte = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = 32'h0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      csr_write(tlvmc_pkg::CSR_IDX_RAW_TYPE, 32'h0000_00ff);
      csr_write(tlvmc_pkg::CSR_IDX_WANTED, 32'hffff_ffff);

      // single byte and seven bytes: both too short
      msg_q = '{8'h00};
      send_range(0, msg_q.size());
      msg_q = '{8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
      send_range(0, msg_q.size());
      // header alone, good then with the wrong type byte
      msg_q.delete();
      prepend_header(32'h0000_00ff, 32'h0);
      send_range(0, msg_q.size());
      msg_q.delete();
      prepend_header(32'hffff_ff00, 32'h0);
      send_range(0, msg_q.size());
      // matching empty record on the last byte: match then verdict
      msg_q.delete();
      push_word(32'hffff_ffff);
      push_word(32'h0);
      prepend_header(32'h0000_00ff, 32'd8);
      send_range(0, msg_q.size());
      // non-matching record, then a record header cut short
      msg_q.delete();
      push_word(32'h0);
      push_word(32'd1);
      msg_q.push_back(8'ha5);
      msg_q.push_back(8'h01);
      msg_q.push_back(8'h02);
      msg_q.push_back(8'h03);
      prepend_header(32'h0000_00ff, msg_q.size());
      send_range(0, msg_q.size());

      // registers change while a message is half way in
      msg_q.delete();
      push_word(32'h0);
      push_word(32'd2);
      msg_q.push_back(8'h5a);
      msg_q.push_back(8'hc3);
      prepend_header(32'h1234_5600, msg_q.size());
      send_range(0, 3);
      wait_drain();
      csr_write(tlvmc_pkg::CSR_IDX_RAW_TYPE, 32'h0);
      send_range(3, 12);
      wait_drain();
      csr_write(tlvmc_pkg::CSR_IDX_WANTED, 32'h0);
      send_range(12, msg_q.size());

      for (int p = 0; p < 5; p++) begin
         wait_drain();
         raw_pick = (p == 0) ? 8'h00 : (p == 1) ? 8'hff : 8'($urandom);
         wanted_pick = (p == 0) ? 32'hffff_ffff : (p == 1) ? 32'h0 : $urandom;
         csr_write(tlvmc_pkg::CSR_IDX_RAW_TYPE, {24'h0, raw_pick});
         csr_write(tlvmc_pkg::CSR_IDX_WANTED, wanted_pick);
         idle_on = (p != 1);
         if (p == 2) hold_req = 1'b1;
         phase_start = sent_bytes;
         while (sent_bytes - phase_start < PHASE_BYTES) begin
            build_random_message();
            send_range(0, msg_q.size());
         end
      end

      wait_drain();
      if (walker.errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+src
src/tlvmc_pkg.sv
src/tlvmc_front.sv
src/tlvmc_queue.sv
src/tlvmc_back.sv
src/tlv_message_checker.sv
bench/tb_tlv_message_checker.sv
